/* src/gds_pkg.sv */
// Shared types, constants and the share function of the diffusion stencil.
`default_nettype none

package gds_pkg;

  localparam int unsigned AMT_W         = 24;
  localparam int unsigned RATE_W        = 14;
  localparam int unsigned PROD_W        = AMT_W + RATE_W;
  localparam int unsigned SHARE_W       = PROD_W - 16;
  localparam int unsigned GW_W          = 7;
  localparam int unsigned GH_W          = 16;
  localparam int unsigned ADDR_W        = 4;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned DEF_MAX_WIDTH = 64;

  localparam logic [GW_W-1:0]   GW_RESET = 7'd64;
  localparam logic [GH_W-1:0]   GH_RESET = 16'd64;
  localparam logic [RATE_W-1:0] SR_RESET = 14'd3277;
  localparam logic [RATE_W-1:0] DR_RESET = 14'd2317;
  localparam logic [AMT_W-1:0]  AMT_MAX  = 24'hFFFFFF;

  // Register indexes, byte address 4*index
  typedef enum logic [1:0] {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_STRAIGHT_RATE,
    REG_DIAGONAL_RATE
  } reg_e;

  typedef logic [AMT_W-1:0]   amount_t;
  typedef logic [SHARE_W-1:0] share_t;

  typedef struct packed {
    logic [GW_W-1:0]   grid_width;
    logic [GH_W-1:0]   grid_height;
    logic [RATE_W-1:0] straight_rate;
    logic [RATE_W-1:0] diagonal_rate;
  } cfg_t;

  // Per-word control that travels with the data down the pipeline
  typedef struct packed {
    logic emit;
    logic last;
    logic top;
    logic bottom;
    logic left;
    logic right;
  } flags_t;

  // Amount times Q0.16 rate, truncated
  function automatic share_t share(amount_t amount, logic [RATE_W-1:0] rate);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(amount) * PROD_W'(rate);
    return prod[PROD_W-1:16];
  endfunction

endpackage

`default_nettype wire

/* src/gds_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gds_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/gds_cfg.sv */
// APB register file for grid geometry and diffusion rates.
`default_nettype none

module gds_cfg import gds_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o,
  output logic                   geom_wr_o
);

  cfg_t cfg_d, cfg_q;
  reg_e idx;
  logic wr;

  assign pready = 1'b1;
  assign idx    = reg_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  // Decode write
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_GRID_WIDTH:    cfg_d.grid_width    = pwdata[GW_W-1:0];
        REG_GRID_HEIGHT:   cfg_d.grid_height   = pwdata[GH_W-1:0];
        REG_STRAIGHT_RATE: cfg_d.straight_rate = pwdata[RATE_W-1:0];
        REG_DIAGONAL_RATE: cfg_d.diagonal_rate = pwdata[RATE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width    <= GW_RESET;
      cfg_q.grid_height   <= GH_RESET;
      cfg_q.straight_rate <= SR_RESET;
      cfg_q.diagonal_rate <= DR_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_GRID_WIDTH:    prdata = DATA_W'(cfg_q.grid_width);
      REG_GRID_HEIGHT:   prdata = DATA_W'(cfg_q.grid_height);
      REG_STRAIGHT_RATE: prdata = DATA_W'(cfg_q.straight_rate);
      REG_DIAGONAL_RATE: prdata = DATA_W'(cfg_q.diagonal_rate);
    endcase
  end

  // Geometry change restarts the frame
  assign geom_wr_o = wr && ((idx == REG_GRID_WIDTH) || (idx == REG_GRID_HEIGHT));
  assign cfg_o     = cfg_q;

endmodule

`default_nettype wire

/* src/gds_seq.sv */
// Frame sequencer: input and output positions, emit and boundary decisions.
`default_nettype none

module gds_seq import gds_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  cfg_t               cfg_i,
  input  wire logic          geom_wr_i,
  input  wire logic          accept_i,
  input  wire logic          kind_i,
  output logic               take_o,
  output flags_t             flags_o,
  output logic      [CW-1:0] wr_col_o,
  output logic      [CW-1:0] rd_col_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DW = $clog2(MAX_WIDTH + 2);

  logic [WW-1:0]   eff_w, w_m1;
  logic [GH_W-1:0] eff_h, h_m1;
  logic [DW-1:0]   w_p1;

  logic [CW-1:0]   in_col_d, in_col_q, out_col_d, out_col_q, wr_col_d, wr_col_q;
  logic [GH_W-1:0] in_row_d, in_row_q, out_row_d, out_row_q;
  logic [DW-1:0]   lead_d, lead_q;
  logic [CW-1:0]   wr_col_nxt;

  logic rows_done, cell_ok, flush_ok, emit, last;

  // Clamp geometry
  always_comb begin
    if (cfg_i.grid_width < 7'd3) begin
      eff_w = WW'(3);
    end else if (32'(cfg_i.grid_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_i.grid_width);
    end
  end

  assign eff_h = (cfg_i.grid_height == '0) ? GH_W'(1) : cfg_i.grid_height;
  assign w_m1  = eff_w - WW'(1);
  assign h_m1  = eff_h - GH_W'(1);
  assign w_p1  = DW'(eff_w) + DW'(1);

  // Decide what this word does
  assign rows_done = (in_row_q >= eff_h);
  assign cell_ok   = !kind_i && !rows_done;
  assign flush_ok  = kind_i && rows_done && (lead_q != '0);
  assign emit      = flush_ok || (cell_ok && (lead_q == w_p1));
  assign last      = emit && (WW'(out_col_q) == w_m1) && (out_row_q == h_m1);

  assign take_o         = cell_ok || flush_ok;
  assign flags_o.emit   = emit;
  assign flags_o.last   = last;
  assign flags_o.top    = (out_row_q == '0);
  assign flags_o.bottom = (out_row_q == h_m1);
  assign flags_o.left   = (out_col_q == '0);
  assign flags_o.right  = (WW'(out_col_q) == w_m1);

  // Line buffer column; a single-row frame reads one column ahead
  assign wr_col_nxt = (WW'(wr_col_q) == w_m1) ? '0 : wr_col_q + CW'(1);
  assign wr_col_o   = wr_col_q;
  assign rd_col_o   = (eff_h == GH_W'(1)) ? wr_col_nxt : wr_col_q;

  // Advance positions
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    wr_col_d  = wr_col_q;
    lead_d    = lead_q;
    if (geom_wr_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      wr_col_d  = '0;
      lead_d    = '0;
    end else if (accept_i && take_o) begin
      wr_col_d = wr_col_nxt;
      if (cell_ok) begin
        if (WW'(in_col_q) == w_m1) begin
          in_col_d = '0;
          in_row_d = in_row_q + GH_W'(1);
        end else begin
          in_col_d = in_col_q + CW'(1);
        end
        if (!emit) begin
          lead_d = lead_q + DW'(1);
        end
      end else begin
        lead_d = lead_q - DW'(1);
      end
      if (emit) begin
        if (WW'(out_col_q) == w_m1) begin
          out_col_d = '0;
          out_row_d = out_row_q + GH_W'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
      if (last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
        wr_col_d  = '0;
        lead_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      wr_col_q  <= '0;
      lead_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      wr_col_q  <= wr_col_d;
      lead_q    <= lead_d;
    end
  end

endmodule

`default_nettype wire

/* src/gds_window.sv */
// Two row line buffers and the 3x3 window, with the first two pipeline stages.
`default_nettype none

module gds_window import gds_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  flags_t                 flags_i,
  input  amount_t                amount_i,
  input  wire logic     [CW-1:0] wr_col_i,
  input  wire logic     [CW-1:0] rd_col_i,
  input  wire logic              arith_ready_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output flags_t                 flags_o,
  output amount_t [2:0][2:0]     win_o
);

  logic             s1_v_q, s2_v_q;
  flags_t           s1_flags_q, s2_flags_q;
  amount_t          s1_amt_q;
  logic [CW-1:0]    s1_col_q;
  amount_t          a_rdata, b_rdata;
  amount_t [2:0][2:0] win_q;
  logic             en1, en2;

  // Stage enables: a non-emitting word leaves the window stage freely
  assign en2     = !s2_v_q || !s2_flags_q.emit || arith_ready_i;
  assign en1     = !s1_v_q || en2;
  assign ready_o = en1;

  // Line buffer for the row above the newest word
  gds_ram #(
    .WIDTH (AMT_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_a (
    .clk_i   (clk_i),
    .we_i    (take_i),
    .waddr_i (wr_col_i),
    .wdata_i (amount_i),
    .re_i    (take_i),
    .raddr_i (rd_col_i),
    .rdata_o (a_rdata)
  );

  // Line buffer two rows up, fed from the first one
  gds_ram #(
    .WIDTH (AMT_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_b (
    .clk_i   (clk_i),
    .we_i    (s1_v_q && en2),
    .waddr_i (s1_col_q),
    .wdata_i (a_rdata),
    .re_i    (take_i),
    .raddr_i (wr_col_i),
    .rdata_o (b_rdata)
  );

  // Stage one: word waits for line buffer data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en1) begin
      s1_v_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_flags_q <= flags_i;
      s1_amt_q   <= amount_i;
      s1_col_q   <= wr_col_i;
    end
  end

  // Stage two: shift the new column into the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      win_q  <= '0;
    end else if (en2) begin
      s2_v_q <= s1_v_q;
      if (s1_v_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= b_rdata;
        win_q[1][2] <= a_rdata;
        win_q[2][2] <= s1_amt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_v_q) begin
      s2_flags_q <= s1_flags_q;
    end
  end

  assign valid_o = s2_v_q && s2_flags_q.emit;
  assign flags_o = s2_flags_q;
  assign win_o   = win_q;

endmodule

`default_nettype wire

/* src/gds_arith.sv */
// Share products, balance sum with saturation, and the output register.
`default_nettype none

module gds_arith import gds_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  flags_t                 flags_i,
  input  amount_t [2:0][2:0]     win_i,
  input  wire logic [RATE_W-1:0] straight_rate_i,
  input  wire logic [RATE_W-1:0] diagonal_rate_i,
  output logic                   ready_o,
  output logic                   m_valid_o,
  input  wire logic              m_ready_i,
  output amount_t                m_amount_o,
  output logic                   m_last_o
);

  localparam int unsigned ACC_W = AMT_W + 4;

  logic n_ok, s_ok, w_ok, e_ok;
  share_t [7:0] nb;
  logic [2:0]   ns, nd;

  logic         s3_v_q, out_v_q;
  share_t [7:0] nb_q;
  share_t       self_s_q, self_d_q;
  amount_t      self_q;
  logic [2:0]   ns_q, nd_q;
  logic         s3_last_q;
  amount_t      out_amt_q;
  logic         out_last_q;

  logic [ACC_W-1:0] gain, loss, diff;
  amount_t          result;
  logic             en3, en4;

  assign en4     = !out_v_q || m_ready_i;
  assign en3     = !s3_v_q || en4;
  assign ready_o = en3;

  // In-bounds neighbours
  assign n_ok = !flags_i.top;
  assign s_ok = !flags_i.bottom;
  assign w_ok = !flags_i.left;
  assign e_ok = !flags_i.right;

  // Neighbour shares, dropped where out of bounds
  always_comb begin
    nb[0] = e_ok ? share(win_i[1][2], straight_rate_i) : '0;
    nb[1] = w_ok ? share(win_i[1][0], straight_rate_i) : '0;
    nb[2] = s_ok ? share(win_i[2][1], straight_rate_i) : '0;
    nb[3] = n_ok ? share(win_i[0][1], straight_rate_i) : '0;
    nb[4] = (s_ok && e_ok) ? share(win_i[2][2], diagonal_rate_i) : '0;
    nb[5] = (n_ok && e_ok) ? share(win_i[0][2], diagonal_rate_i) : '0;
    nb[6] = (s_ok && w_ok) ? share(win_i[2][0], diagonal_rate_i) : '0;
    nb[7] = (n_ok && w_ok) ? share(win_i[0][0], diagonal_rate_i) : '0;
    ns = 3'(n_ok) + 3'(s_ok) + 3'(w_ok) + 3'(e_ok);
    nd = 3'(n_ok && e_ok) + 3'(n_ok && w_ok) + 3'(s_ok && e_ok) + 3'(s_ok && w_ok);
  end

  // Stage three: register the products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en3) begin
      s3_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && valid_i) begin
      nb_q      <= nb;
      self_q    <= win_i[1][1];
      self_s_q  <= share(win_i[1][1], straight_rate_i);
      self_d_q  <= share(win_i[1][1], diagonal_rate_i);
      ns_q      <= ns;
      nd_q      <= nd;
      s3_last_q <= flags_i.last;
    end
  end

  // Balance: keep, lose what was sent, gain what came in; clamp both ends
  always_comb begin
    gain = ACC_W'(self_q);
    for (int k = 0; k < 8; k++) begin
      gain = gain + ACC_W'(nb_q[k]);
    end
    loss = ACC_W'(ns_q) * ACC_W'(self_s_q) + ACC_W'(nd_q) * ACC_W'(self_d_q);
    diff = gain - loss;
    if (loss > gain) begin
      result = '0;
    end else if (diff > ACC_W'(AMT_MAX)) begin
      result = AMT_MAX;
    end else begin
      result = diff[AMT_W-1:0];
    end
  end

  // Output register holds the word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en4) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && s3_v_q) begin
      out_amt_q  <= result;
      out_last_q <= s3_last_q;
    end
  end

  assign m_valid_o  = out_v_q;
  assign m_amount_o = out_amt_q;
  assign m_last_o   = out_last_q;

endmodule

`default_nettype wire

/* src/grid_diffusion_stencil.sv */
// Pipeline: a result word passes all four register stages (stages one to three, output),
// released by the input word grid_width+1 words after its own cell (flush words release
// the last ones). Throughput: one word per cycle unless the output stalls, set by the
// two row line buffers, each a RAM with one write and one registered read per cycle.
// Reset: asynchronous, active low; clears positions, stage valids and the window and
// loads register defaults. Line buffer RAMs are not cleared: no stale entry is used.
`default_nettype none

module grid_diffusion_stencil import gds_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  // Input stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [23:0]       s_axis_tdata,   // [23:0] cell_amount
  input  wire logic [0:0]        s_axis_tuser,   // [0] kind
  // Output stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [23:0]       m_axis_tdata,   // [23:0] next_amount
  output logic                   m_axis_tlast
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  cfg_t               cfg;
  logic               geom_wr;
  logic               accept, take;
  flags_t             seq_flags, win_flags;
  logic [CW-1:0]      wr_col, rd_col;
  amount_t            amount;
  logic               arith_ready, win_valid;
  amount_t [2:0][2:0] win;

  gds_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .geom_wr_o (geom_wr)
  );

  assign accept = s_axis_tvalid && s_axis_tready;
  // Flush words push a zero column through the line buffers
  assign amount = s_axis_tuser[0] ? '0 : s_axis_tdata;

  gds_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .geom_wr_i (geom_wr),
    .accept_i  (accept),
    .kind_i    (s_axis_tuser[0]),
    .take_o    (take),
    .flags_o   (seq_flags),
    .wr_col_o  (wr_col),
    .rd_col_o  (rd_col)
  );

  gds_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (accept && take),
    .flags_i       (seq_flags),
    .amount_i      (amount),
    .wr_col_i      (wr_col),
    .rd_col_i      (rd_col),
    .arith_ready_i (arith_ready),
    .ready_o       (s_axis_tready),
    .valid_o       (win_valid),
    .flags_o       (win_flags),
    .win_o         (win)
  );

  gds_arith u_arith (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (win_valid),
    .flags_i         (win_flags),
    .win_i           (win),
    .straight_rate_i (cfg.straight_rate),
    .diagonal_rate_i (cfg.diagonal_rate),
    .ready_o         (arith_ready),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_amount_o      (m_axis_tdata),
    .m_last_o        (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* src/gds_checker.sv */
// Port-level checker for the diffusion stencil and its bind to the top level.
`default_nettype none

module gds_checker import gds_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [ADDR_W-1:0] paddr,
  input wire logic [DATA_W-1:0] pwdata,
  input wire logic [DATA_W-1:0] prdata,
  input wire logic              pready,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic [23:0]       s_axis_tdata,
  input wire logic [0:0]        s_axis_tuser,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [23:0]       m_axis_tdata,
  input wire logic              m_axis_tlast
);

  // A stalled result word holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result word changed");

  // With the output register empty the whole pipeline can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // Width register reads back what was written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rst_ni && psel && penable && pwrite && pready && (paddr[3:2] == REG_GRID_WIDTH))
      ##1 (psel && !pwrite && (paddr[3:2] == REG_GRID_WIDTH))
      |-> (prdata[GW_W-1:0] == $past(pwdata[GW_W-1:0])) && (prdata[DATA_W-1:GW_W] == '0))
    else $error("grid_width readback mismatch");

  // Straight rate register reads back what was written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rst_ni && psel && penable && pwrite && pready && (paddr[3:2] == REG_STRAIGHT_RATE))
      ##1 (psel && !pwrite && (paddr[3:2] == REG_STRAIGHT_RATE))
      |-> (prdata[RATE_W-1:0] == $past(pwdata[RATE_W-1:0]))
        && (prdata[DATA_W-1:RATE_W] == '0))
    else $error("straight_rate readback mismatch");

endmodule

bind grid_diffusion_stencil gds_checker u_gds_checker (.*);

`default_nettype wire
